/* src/rsq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rsq_pkg;

    // Fixed field widths on the stream ports
    localparam int SRC_IN_W = 3;
    localparam int SEQ_W    = 32;
    localparam int PAY_IN_W = 32;
    localparam int TDATA_W  = 72;

    // Widest internal indexes over the legal parameter range
    localparam int SRC_MAX_W  = 6;
    localparam int MOD_MAX_W  = 6;
    localparam int ADDR_MAX_W = 12;

    // Run requests waiting between front and back
    localparam int QUEUE_DEPTH = 2;

    // Highest sequence number; a source that reaches it takes nothing more
    localparam logic [SEQ_W-1:0] SEQ_MAX = 32'hFFFF_FFFF;

    // Run request: source, first sequence number and slot index of a deliverable run
    typedef struct packed {
        logic [SRC_MAX_W-1:0] src;
        logic [SEQ_W-1:0]     seq;
        logic [MOD_MAX_W-1:0] mod;
    } qent_t;

    // Back-to-front update, one per delivered word
    typedef struct packed {
        logic                  vld;
        logic                  done;
        logic [SRC_MAX_W-1:0]  src;
        logic [SEQ_W-1:0]      ld;
        logic [MOD_MAX_W-1:0]  ld_mod;
        logic [ADDR_MAX_W-1:0] addr;
    } bk_upd_t;

endpackage

`default_nettype wire

/* src/rsq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/rsq_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module rsq_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire rsq_pkg::qent_t push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output rsq_pkg::qent_t     head_data
);

    localparam int PTR_W = (rsq_pkg::QUEUE_DEPTH > 1) ? $clog2(rsq_pkg::QUEUE_DEPTH) : 1;
    localparam logic [PTR_W:0] CNT_FULL = (PTR_W + 1)'(rsq_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(rsq_pkg::QUEUE_DEPTH - 1);

    rsq_pkg::qent_t   ent_reg [rsq_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head_data  = ent_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* src/rsq_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module rsq_front #(
    parameter int SOURCES      = 8,
    parameter int WINDOW       = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input words
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [rsq_pkg::SRC_IN_W-1:0]         in_src,
    input  wire logic [rsq_pkg::SEQ_W-1:0]            in_seq,
    input  wire logic [rsq_pkg::PAY_IN_W-1:0]         in_pay,
    // run requests toward the back
    output logic                                      q_push,
    output rsq_pkg::qent_t                            q_data,
    input  wire logic                                 q_full,
    // payload store write side
    output logic                                      ram_wr_en,
    output logic [$clog2(SOURCES*WINDOW)-1:0]         ram_wr_addr,
    output logic [PAYLOAD_BITS-1:0]                   ram_wr_data,
    // slot state shared with the back
    output logic [SOURCES*WINDOW-1:0]                 slot_valid,
    input  wire rsq_pkg::bk_upd_t                     upd
);

    localparam int DEPTH  = SOURCES * WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SRC_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int MOD_W  = $clog2(WINDOW);
    localparam logic [MOD_W:0]    WIN_M = (MOD_W + 1)'(WINDOW);
    localparam logic [ADDR_W-1:0] WIN_A = ADDR_W'(WINDOW);

    // Input holding stage
    logic                          in_valid_reg;
    logic [rsq_pkg::SRC_IN_W-1:0]  in_src_reg;
    logic [rsq_pkg::SEQ_W-1:0]     in_seq_reg;
    logic [rsq_pkg::PAY_IN_W-1:0]  in_pay_reg;

    // Per-source state
    logic [rsq_pkg::SEQ_W-1:0] ld_reg    [SOURCES];
    logic [MOD_W-1:0]          ldmod_reg [SOURCES];
    logic [SOURCES-1:0]        busy_reg, busy_next;
    logic [DEPTH-1:0]          valid_reg, valid_next;

    // Classification
    logic                      in_range;
    logic [SRC_W-1:0]          sidx;
    logic [rsq_pkg::SEQ_W-1:0] ld;
    logic [MOD_W-1:0]          ldm;
    logic [rsq_pkg::SEQ_W-1:0] diff;
    logic                      fresh;
    logic                      in_win;
    logic [MOD_W:0]            msum;
    logic [MOD_W-1:0]          mod;
    logic [ADDR_W-1:0]         addr;
    logic                      go;
    logic                      store;
    logic                      push;
    logic [SRC_W-1:0]          usrc;

    always_comb begin
        in_range = {29'd0, in_src_reg} < 32'(SOURCES);
        sidx     = in_range ? SRC_W'(in_src_reg) : '0;
        ld       = ld_reg[sidx];
        ldm      = ldmod_reg[sidx];
        diff     = in_seq_reg - ld;
        fresh    = in_seq_reg > ld;
        in_win   = diff <= 32'(WINDOW);
        // slot = (ld mod W + diff) mod W, with diff no more than W
        msum     = {1'b0, ldm} + diff[MOD_W:0];
        mod      = (msum >= WIN_M) ? MOD_W'(msum - WIN_M) : MOD_W'(msum);
        addr     = ADDR_W'(sidx) * WIN_A + ADDR_W'(mod);
        // a source with a run in flight waits until the back is done with it
        go       = in_valid_reg && (!in_range || (!busy_reg[sidx] && !q_full));
        store    = go && in_range && fresh && in_win;
        // only the next expected number can start a run
        push     = store && (diff == 32'd1);
    end

    assign in_ready = !in_valid_reg || go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            in_src_reg <= in_src;
            in_seq_reg <= in_seq;
            in_pay_reg <= in_pay;
        end
    end

    // Outputs toward queue and store
    assign q_push      = push;
    assign q_data.src  = rsq_pkg::SRC_MAX_W'(sidx);
    assign q_data.seq  = in_seq_reg;
    assign q_data.mod  = rsq_pkg::MOD_MAX_W'(mod);
    assign ram_wr_en   = store;
    assign ram_wr_addr = addr;
    assign ram_wr_data = PAYLOAD_BITS'(in_pay_reg);
    assign slot_valid  = valid_reg;

    // Valid bits and busy flags: front sets, back clears
    assign usrc = SRC_W'(upd.src);

    always_comb begin
        valid_next = valid_reg;
        busy_next  = busy_reg;
        if (upd.vld) begin
            valid_next[ADDR_W'(upd.addr)] = 1'b0;
        end
        if (upd.done) begin
            busy_next[usrc] = 1'b0;
        end
        if (store) begin
            valid_next[addr] = 1'b1;
        end
        if (push) begin
            busy_next[sidx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            busy_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            busy_reg  <= busy_next;
        end
    end

    // Last delivered number, advanced by the back on every word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SOURCES; i++) begin
                ld_reg[i]    <= '0;
                ldmod_reg[i] <= '0;
            end
        end else if (upd.vld) begin
            ld_reg[usrc]    <= upd.ld;
            ldmod_reg[usrc] <= MOD_W'(upd.ld_mod);
        end
    end

endmodule

`default_nettype wire

/* src/rsq_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module rsq_back #(
    parameter int SOURCES      = 8,
    parameter int WINDOW       = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // run requests
    input  wire logic                             q_valid,
    input  wire rsq_pkg::qent_t                   q_data,
    output logic                                  q_pop,
    // slot state and payload store read side
    input  wire logic [SOURCES*WINDOW-1:0]        slot_valid,
    output logic                                  ram_rd_en,
    output logic [$clog2(SOURCES*WINDOW)-1:0]     ram_rd_addr,
    input  wire logic [PAYLOAD_BITS-1:0]          ram_rd_data,
    output rsq_pkg::bk_upd_t                      upd,
    // result words
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [rsq_pkg::SRC_IN_W-1:0]          out_src,
    output logic [rsq_pkg::SEQ_W-1:0]             out_seq,
    output logic [rsq_pkg::PAY_IN_W-1:0]          out_pay,
    output logic                                  out_last
);

    localparam int DEPTH  = SOURCES * WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SRC_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int MOD_W  = $clog2(WINDOW);
    localparam logic [ADDR_W-1:0] WIN_A   = ADDR_W'(WINDOW);
    localparam logic [MOD_W-1:0]  MOD_TOP = MOD_W'(WINDOW - 1);

    // Run walker
    logic                      run_reg, run_next;
    logic [SRC_W-1:0]          src_reg, src_next;
    logic [rsq_pkg::SEQ_W-1:0] cur_reg, cur_next;
    logic [MOD_W-1:0]          cur_mod_reg, cur_mod_next;

    // Read in flight and output register
    logic                          pend_reg;
    logic [SRC_W-1:0]              pend_src_reg;
    logic [rsq_pkg::SEQ_W-1:0]     pend_seq_reg;
    logic                          pend_last_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [rsq_pkg::SRC_IN_W-1:0]  out_src_reg;
    logic [rsq_pkg::SEQ_W-1:0]     out_seq_reg;
    logic [rsq_pkg::PAY_IN_W-1:0]  out_pay_reg;
    logic                          out_last_reg;

    logic [MOD_W-1:0]  next_mod;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] next_addr;
    logic              last;
    logic              issue;
    logic              pop;

    always_comb begin
        next_mod  = (cur_mod_reg == MOD_TOP) ? '0 : cur_mod_reg + 1'b1;
        cur_addr  = ADDR_W'(src_reg) * WIN_A + ADDR_W'(cur_mod_reg);
        next_addr = ADDR_W'(src_reg) * WIN_A + ADDR_W'(next_mod);
        // run ends at the first gap or at the top of the number space
        last      = (cur_reg == rsq_pkg::SEQ_MAX) || !slot_valid[next_addr];
        // issue a read only when the output register is free by the time data lands
        issue     = run_reg && !pend_reg && (!out_valid_reg || out_ready);
        pop       = !run_reg && q_valid;
    end

    assign q_pop       = pop;
    assign ram_rd_en   = issue;
    assign ram_rd_addr = cur_addr;

    assign upd.vld    = issue;
    assign upd.done   = issue && last;
    assign upd.src    = rsq_pkg::SRC_MAX_W'(src_reg);
    assign upd.ld     = cur_reg;
    assign upd.ld_mod = rsq_pkg::MOD_MAX_W'(cur_mod_reg);
    assign upd.addr   = rsq_pkg::ADDR_MAX_W'(cur_addr);

    // Walker next state
    always_comb begin
        run_next     = run_reg;
        src_next     = src_reg;
        cur_next     = cur_reg;
        cur_mod_next = cur_mod_reg;
        if (pop) begin
            run_next     = 1'b1;
            src_next     = SRC_W'(q_data.src);
            cur_next     = q_data.seq;
            cur_mod_next = MOD_W'(q_data.mod);
        end else if (issue) begin
            if (last) begin
                run_next = 1'b0;
            end else begin
                cur_next     = cur_reg + 1'b1;
                cur_mod_next = next_mod;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg     <= src_next;
        cur_reg     <= cur_next;
        cur_mod_reg <= cur_mod_next;
    end

    // Read in flight, then output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (pend_reg) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_reg      <= issue;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            pend_src_reg  <= src_reg;
            pend_seq_reg  <= cur_reg;
            pend_last_reg <= last;
        end
        if (pend_reg) begin
            out_src_reg  <= rsq_pkg::SRC_IN_W'(pend_src_reg);
            out_seq_reg  <= pend_seq_reg;
            out_pay_reg  <= rsq_pkg::PAY_IN_W'(ram_rd_data);
            out_last_reg <= pend_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_src   = out_src_reg;
    assign out_seq   = out_seq_reg;
    assign out_pay   = out_pay_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

/* src/per_source_fifo_resequencer_top.sv */
// Per-source resequencer. Input words on s_* carry a source, a sequence
// number and a payload handle; result words on m_* come out per source in
// strict sequence order, each run closed by m_tlast on its final word.
// Duplicates, words beyond the reorder window and unknown sources are dropped
// without a result; a repeated copy inside the window replaces the stored one.
// The first word of a run passes the input register, the run queue, the walker
// registers, the registered payload RAM read and the output register. The walker
// starts no new read while one is in flight; each read feeds the output register.
// Input words that only store or drop are taken one per cycle, as long as
// their source has no run in flight and the queue is not full; up to two runs
// wait in the queue between the classifier and the run walker.
// Reset clears every last-delivered counter and every slot valid bit at
// once (flip-flops, no clearing pass); the payload RAM is not cleared.
// When m_tready is low the output register holds its word, the walker stops
// issuing reads, and the input side keeps accepting until the queue fills or
// a word arrives for a source whose run is still being delivered.
`timescale 1ns / 1ps
`default_nettype none

module per_source_fifo_resequencer_top #(
    parameter int SOURCES      = 8,
    parameter int WINDOW       = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // source [2:0], seq_num [34:3], payload [66:35], zero [71:67]
    input  wire logic [rsq_pkg::TDATA_W-1:0]   s_tdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // out_source [2:0], out_seq_num [34:3], out_payload [66:35], zero [71:67]
    output logic [rsq_pkg::TDATA_W-1:0]        m_tdata,
    output logic                               m_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready
);

    localparam int DEPTH  = SOURCES * WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SEQ_LO = rsq_pkg::SRC_IN_W;
    localparam int PAY_LO = SEQ_LO + rsq_pkg::SEQ_W;
    localparam int USED_W = PAY_LO + rsq_pkg::PAY_IN_W;

    logic                          q_push;
    rsq_pkg::qent_t                q_wdata;
    logic                          q_full;
    logic                          q_pop;
    logic                          q_valid;
    rsq_pkg::qent_t                q_rdata;
    logic                          ram_wr_en;
    logic [ADDR_W-1:0]             ram_wr_addr;
    logic [PAYLOAD_BITS-1:0]       ram_wr_data;
    logic                          ram_rd_en;
    logic [ADDR_W-1:0]             ram_rd_addr;
    logic [PAYLOAD_BITS-1:0]       ram_rd_data;
    logic [DEPTH-1:0]              slot_valid;
    rsq_pkg::bk_upd_t              upd;
    logic [rsq_pkg::SRC_IN_W-1:0]  out_src;
    logic [rsq_pkg::SEQ_W-1:0]     out_seq;
    logic [rsq_pkg::PAY_IN_W-1:0]  out_pay;

    // Classifier and slot writer
    rsq_front #(
        .SOURCES      (SOURCES),
        .WINDOW       (WINDOW),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_src      (s_tdata[SEQ_LO-1:0]),
        .in_seq      (s_tdata[PAY_LO-1:SEQ_LO]),
        .in_pay      (s_tdata[USED_W-1:PAY_LO]),
        .q_push      (q_push),
        .q_data      (q_wdata),
        .q_full      (q_full),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .slot_valid  (slot_valid),
        .upd         (upd)
    );

    // Run requests between the two sides
    rsq_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_wdata),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_rdata)
    );

    // Payload slots, one window per source
    rsq_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Run walker and output register
    rsq_back #(
        .SOURCES      (SOURCES),
        .WINDOW       (WINDOW),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .slot_valid  (slot_valid),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .upd         (upd),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_src     (out_src),
        .out_seq     (out_seq),
        .out_pay     (out_pay),
        .out_last    (m_tlast)
    );

    assign m_tdata = {{(rsq_pkg::TDATA_W - USED_W){1'b0}}, out_pay, out_seq, out_src};

endmodule

`default_nettype wire
